FILE: design/bmhpq_pkg.sv
// ----------------------------------------------------------------------------
// bmhpq_pkg: shared definitions for the binary max-heap priority queue
// Key and field widths, operation codes, reset values and the result record.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int CFG_W        = 7;
  localparam int CNT_OUT_W    = 7;
  localparam int CAPACITY_DEF = 64;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // Operation codes of a request.
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic                    found;
    logic                    dropped;
    logic [CNT_OUT_W-1:0]    count_now;
  } res_t;

endpackage

FILE: design/bmhpq_if.sv
// ----------------------------------------------------------------------------
// bmhpq_if: channel interfaces of the heap priority queue
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bmhpq_req_if;
  import bmhpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KEY_W-1:0] key_in;
  modport source (output valid, op, key_in, input ready);
  modport sink   (input valid, op, key_in, output ready);
endinterface

interface bmhpq_rsp_if;
  import bmhpq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key_out;
  logic                    found;
  logic                    dropped;
  logic [CNT_OUT_W-1:0]    count_now;
  modport source (output valid, key_out, found, dropped, count_now, input ready);
  modport sink   (input valid, key_out, found, dropped, count_now, output ready);
endinterface

interface bmhpq_cfg_if;
  import bmhpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_entries;
  modport source (output valid, max_entries, input ready);
  modport sink   (input valid, max_entries, output ready);
endinterface

FILE: design/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue: max-heap priority queue of signed keys
// Insert and extract-maximum requests over a memory-backed binary heap.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                                 handshake
//   req_i    in         op, key_in                              valid/ready
//   rsp_o    out        key_out, found, dropped, count_now      valid/ready
//   cfg_i    in         max_entries                             valid/ready
//
// A request with no tree walk (full insert, empty extract, insert into an empty
// heap) goes straight to S_DONE, and an extract from one or two keys passes only
// S_EXT; otherwise the sequencer moves L keys, at most log2(CAPACITY), through
// S_UP or S_DOWN; the key memory's single write port walks one level per cycle.
// Reset clears the entry count and sets max_entries to 64, not the key memory.
// A stalled response waits in the output register while the next request runs.
//
module binary_max_heap_priority_queue #(
  parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmhpq_req_if.sink   req_i,
  bmhpq_rsp_if.source rsp_o,
  bmhpq_cfg_if.sink   cfg_i
);
  import bmhpq_pkg::*;

  // Configured limit on the number of keys held.
  logic [CFG_W-1:0] max_entries_q;

  // Output register parting the sequencer from the response channel.
  logic out_valid_q;
  res_t out_res_q;

  logic res_valid;
  logic res_ready;
  res_t res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (cfg_i.valid) begin
      max_entries_q <= cfg_i.max_entries;
    end
  end

  bmhpq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_i),
    .max_entries_i (max_entries_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // The sequencer may hand over a result whenever the register is empty or
  // is being drained in this same cycle.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.key_out   = out_res_q.key_out;
  assign rsp_o.found     = out_res_q.found;
  assign rsp_o.dropped   = out_res_q.dropped;
  assign rsp_o.count_now = out_res_q.count_now;

endmodule

FILE: design/bmhpq_mem.sv
// ----------------------------------------------------------------------------
// bmhpq_mem: heap key storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhpq_mem #(
  parameter int DEPTH = bmhpq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [bmhpq_pkg::KEY_W-1:0] wdata_i,
  input  logic [AW-1:0]                     raddr_a_i,
  input  logic [AW-1:0]                     raddr_b_i,
  output logic signed [bmhpq_pkg::KEY_W-1:0] rdata_a_o,
  output logic signed [bmhpq_pkg::KEY_W-1:0] rdata_b_o
);
  import bmhpq_pkg::*;

  logic signed [KEY_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: design/bmhpq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhpq_ctrl: heap sequencer
// Walks the sift-up and sift-down paths over the key memory with a hole.
// ----------------------------------------------------------------------------
module bmhpq_ctrl #(
  parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bmhpq_req_if.sink                     req,
  input  logic [bmhpq_pkg::CFG_W-1:0]   max_entries_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bmhpq_pkg::res_t               res_o
);
  import bmhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_EXT  = 6'b000100,
    S_DOWN = 6'b001000,
    S_PUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [KEY_W-1:0] res_key_q, res_key_d;
  logic                    res_found_q, res_found_d;
  logic                    res_dropped_q, res_dropped_d;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [KEY_W-1:0] wdata;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic signed [KEY_W-1:0] rdata_a, rdata_b;

  logic                    full;
  logic [AW-1:0]           parent;
  logic [XW-1:0]           lc, rc, nl;
  logic                    rc_ok, take_right;
  logic signed [KEY_W-1:0] cval;
  logic [AW-1:0]           cidx;
  logic [LW-1:0]           count_ext;

  bmhpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign full = (count_q >= CW'(CAPACITY)) || (LW'(count_q) >= LW'(max_entries_i));
  assign parent = AW'((pos_q - AW'(1)) >> 1);

  // Sift-down child selection; the left child wins a tie.
  assign lc         = XW'({pos_q, 1'b1});
  assign rc         = lc + XW'(1);
  assign rc_ok      = rc < XW'(count_q);
  assign take_right = rc_ok && (rdata_a < rdata_b);
  assign cval       = take_right ? rdata_b : rdata_a;
  assign cidx       = take_right ? rc[AW-1:0] : lc[AW-1:0];
  assign nl         = XW'({cidx, 1'b1});

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    pos_d         = pos_q;
    key_d         = key_q;
    res_key_d     = res_key_q;
    res_found_d   = res_found_q;
    res_dropped_d = res_dropped_q;
    we            = 1'b0;
    waddr         = pos_q;
    wdata         = key_q;
    raddr_a       = '0;
    raddr_b       = '0;
    req.ready     = 1'b0;
    res_valid_o   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_key_d     = '0;
          res_found_d   = 1'b0;
          res_dropped_d = 1'b0;
          if (req.op == OP_INSERT) begin
            if (full) begin
              res_dropped_d = 1'b1;
              state_d       = S_DONE;
            end else begin
              count_d = count_q + CW'(1);
              key_d   = req.key_in;
              pos_d   = AW'(count_q);
              if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = req.key_in;
                state_d = S_DONE;
              end else begin
                raddr_a = AW'((count_q - CW'(1)) >> 1);
                state_d = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              state_d = S_DONE;
            end else begin
              res_found_d = 1'b1;
              raddr_a     = '0;
              raddr_b     = AW'(count_q - CW'(1));
              state_d     = S_EXT;
            end
          end
        end
      end

      S_UP: begin
        // Parent key is on port A; move it down while it is smaller.
        if (rdata_a < key_q) begin
          we    = 1'b1;
          wdata = rdata_a;
          pos_d = parent;
          if (parent == '0) begin
            state_d = S_PUT;
          end else begin
            raddr_a = AW'((parent - AW'(1)) >> 1);
          end
        end else begin
          we      = 1'b1;
          state_d = S_DONE;
        end
      end

      S_EXT: begin
        // Root is on port A, last entry on port B.
        res_key_d = rdata_a;
        key_d     = rdata_b;
        count_d   = count_q - CW'(1);
        pos_d     = '0;
        if (count_q == CW'(1)) begin
          state_d = S_DONE;
        end else if (count_q == CW'(2)) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = rdata_b;
          state_d = S_DONE;
        end else begin
          raddr_a = AW'(1);
          raddr_b = AW'(2);
          state_d = S_DOWN;
        end
      end

      S_DOWN: begin
        if (key_q < cval) begin
          we    = 1'b1;
          wdata = cval;
          pos_d = cidx;
          if (nl >= XW'(count_q)) begin
            state_d = S_PUT;
          end else begin
            raddr_a = nl[AW-1:0];
            raddr_b = AW'(nl + XW'(1));
          end
        end else begin
          we      = 1'b1;
          state_d = S_DONE;
        end
      end

      S_PUT: begin
        we      = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q         <= pos_d;
    key_q         <= key_d;
    res_key_q     <= res_key_d;
    res_found_q   <= res_found_d;
    res_dropped_q <= res_dropped_d;
  end

  assign count_ext       = LW'(count_q);
  assign res_o.key_out   = res_key_q;
  assign res_o.found     = res_found_q;
  assign res_o.dropped   = res_dropped_q;
  assign res_o.count_now = count_ext[CNT_OUT_W-1:0];

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the binary max-heap priority queue
// Drives insert and extract requests and limit writes, keeps a heap of its
// own to predict every response and checks each response field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bmhpq_pkg::*;

  localparam int HEAP_CAP    = CAPACITY_DEF;
  localparam int IDLE_PCT    = 20;
  localparam int NUM_PHASES  = 13;
  localparam int PHASE_ITEMS = 100;
  localparam int SHOWN_ERRS  = 10;
  // A limit code below zero picks a random setting for that phase.
  localparam int LIM_RAND_LOW  = -1;
  localparam int LIM_RAND_HIGH = -2;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of the directed table: a request, or a write of the entry limit.
  // Rows with a hand-typed response carry it in want; the rest are predicted.
  typedef struct {
    row_kind_e               kind;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic [CFG_W-1:0]        limit;
    bit                      typed;
    res_t                    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bmhpq_req_if req_if ();
  bmhpq_rsp_if rsp_if ();
  bmhpq_cfg_if cfg_if ();

  binary_max_heap_priority_queue DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Our own copy of the heap, its fill level and the programmed limit.
  logic signed [KEY_W-1:0] heap_keys_q [HEAP_CAP];
  int                      heap_fill;
  int                      entry_limit;

  // Responses still owed by the block, oldest first.
  res_t      owed_responses[$];
  stim_row_t directed_rows[$];

  int  mismatches;
  int  responses_checked;
  int  n_inserts;
  int  n_extracts;
  int  n_refused;
  int  n_empty_pops;
  int  n_limit_writes;
  int  deepest_fill;
  int  rsp_hold_left;
  bit  no_idle;

  always #5 clk = ~clk;

  // Applies one request to the shadow heap and returns the response it must
  // produce. Sifting follows the block: an insert climbs while its parent is
  // strictly smaller, an extract sinks toward the larger child, and the left
  // child wins when both children hold the same key.
  function automatic res_t heap_apply(logic op, logic signed [KEY_W-1:0] key);
    res_t                    rsp;
    int                      pos;
    int                      up;
    int                      lc;
    int                      rc;
    int                      best;
    int                      lim;
    logic signed [KEY_W-1:0] tmp;
    rsp = '0;
    // A limit beyond the array size behaves as the array size.
    lim = (entry_limit > HEAP_CAP) ? HEAP_CAP : entry_limit;
    if (op == OP_INSERT) begin
      if (heap_fill >= lim) begin
        rsp.dropped = 1'b1;
      end else begin
        heap_keys_q[heap_fill] = key;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys_q[up] >= heap_keys_q[pos]) break;
          tmp = heap_keys_q[up];
          heap_keys_q[up] = heap_keys_q[pos];
          heap_keys_q[pos] = tmp;
          pos = up;
        end
      end
    end else if (heap_fill > 0) begin
      rsp.key_out = heap_keys_q[0];
      rsp.found = 1'b1;
      heap_keys_q[0] = heap_keys_q[heap_fill-1];
      heap_fill--;
      pos = 0;
      while (1) begin
        lc = 2 * pos + 1;
        rc = lc + 1;
        best = pos;
        if (lc >= heap_fill) break;
        if (heap_keys_q[best] < heap_keys_q[lc]) best = lc;
        if (rc < heap_fill && heap_keys_q[best] < heap_keys_q[rc]) best = rc;
        if (best == pos) break;
        tmp = heap_keys_q[pos];
        heap_keys_q[pos] = heap_keys_q[best];
        heap_keys_q[best] = tmp;
        pos = best;
      end
    end
    rsp.count_now = heap_fill[CNT_OUT_W-1:0];
    return rsp;
  endfunction

  // Directed table builders: a predicted request, a request with its
  // response typed in, and a limit write.
  function automatic void add_req(logic op, logic signed [KEY_W-1:0] key);
    stim_row_t r;
    r = '{kind: ROW_REQ, op: op, key: key, limit: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_chk(logic op, logic signed [KEY_W-1:0] key,
                                  logic signed [KEY_W-1:0] k_out, logic fnd,
                                  logic drp, logic [CNT_OUT_W-1:0] cnt);
    stim_row_t r;
    r = '{kind: ROW_REQ, op: op, key: key, limit: '0, typed: 1'b1, want: '0};
    r.want.key_out = k_out;
    r.want.found = fnd;
    r.want.dropped = drp;
    r.want.count_now = cnt;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] lim);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: OP_INSERT, key: '0, limit: lim, typed: 1'b0, want: '0};
    directed_rows.push_back(r);
  endfunction

  // Offers one request on the falling edge, with random idle gaps first, and
  // returns right after the rising edge that accepts it. Valid stays high on
  // return so that a following request can go out back to back.
  task automatic send_request(logic op, logic signed [KEY_W-1:0] key,
                              bit typed, res_t want);
    res_t predicted;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid  = 1'b1;
    req_if.op     = op;
    req_if.key_in = key;
    do @(posedge clk); while (!req_if.ready);
    predicted = heap_apply(op, key);
    owed_responses.push_back(typed ? want : predicted);
    if (op == OP_INSERT) begin
      n_inserts++;
      if (predicted.dropped) n_refused++;
    end else begin
      n_extracts++;
      if (!predicted.found) n_empty_pops++;
    end
    if (heap_fill > deepest_fill) deepest_fill = heap_fill;
  endtask

  // Takes the request channel down and waits until every owed response is in.
  task automatic drain_responses();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
  endtask

  // The limit register is only written while the block is idle. Every request
  // yields a response, so an empty list of owed responses means idle.
  task automatic write_limit(logic [CFG_W-1:0] lim);
    drain_responses();
    @(negedge clk);
    cfg_if.valid       = 1'b1;
    cfg_if.max_entries = lim;
    do @(posedge clk); while (!cfg_if.ready);
    entry_limit = lim;
    n_limit_writes++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Response side: ready changes on the falling edge. A requested hold-off
  // keeps ready low for a counted stretch while the sender keeps going.
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_if.ready = 1'b0;
      rsp_hold_left--;
    end else if (no_idle) begin
      rsp_if.ready = 1'b1;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every accepted response is matched against the oldest owed one.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      responses_checked++;
      if (owed_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRS)
          $display("ERROR: response with none owed: key %0d found %0b dropped %0b count %0d",
                   rsp_if.key_out, rsp_if.found, rsp_if.dropped, rsp_if.count_now);
      end else begin
        want = owed_responses.pop_front();
        if (rsp_if.key_out !== want.key_out || rsp_if.found !== want.found ||
            rsp_if.dropped !== want.dropped || rsp_if.count_now !== want.count_now) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRS) begin
            $write("ERROR: response %0d: expected key %0d found %0b dropped %0b count %0d, ",
                   responses_checked, want.key_out, want.found, want.dropped,
                   want.count_now);
            $display("got key %0d found %0b dropped %0b count %0d",
                     rsp_if.key_out, rsp_if.found, rsp_if.dropped, rsp_if.count_now);
          end
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                      ph;
    int                      i;
    int                      lim_code;
    int                      fill_pct;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    stim_row_t               row;
    int                      phase_limit [NUM_PHASES];

    phase_limit = '{64, 127, 1, 0, 5, 64, LIM_RAND_LOW, 2, LIM_RAND_HIGH, 64,
                    LIM_RAND_LOW, 17, 127};

    clk                = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.op          = OP_INSERT;
    req_if.key_in      = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.max_entries = '0;
    rsp_if.ready       = 1'b0;
    mismatches         = 0;
    responses_checked  = 0;
    n_inserts          = 0;
    n_extracts         = 0;
    n_refused          = 0;
    n_empty_pops       = 0;
    n_limit_writes     = 0;
    deepest_fill       = 0;
    rsp_hold_left      = 0;
    no_idle            = 1'b0;
    heap_fill          = 0;
    entry_limit        = MAX_ENTRIES_RST;
    foreach (heap_keys_q[k]) heap_keys_q[k] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. It opens on an empty heap, stores the extreme keys and
    // a tie, lowers the limit below the fill level, tries a zero limit, a
    // limit above the array size and the smallest nonzero limit, and pops
    // until the heap runs dry. Extracts carry junk keys that must be ignored.
    add_chk(OP_EXTRACT, 32'sh5A5A5A5A, 32'sd0, 1'b0, 1'b0, 7'd0);
    add_chk(OP_INSERT,  32'sh7FFFFFFF, 32'sd0, 1'b0, 1'b0, 7'd1);
    add_chk(OP_INSERT,  32'sh80000000, 32'sd0, 1'b0, 1'b0, 7'd2);
    add_req(OP_INSERT,  32'sd0);
    add_req(OP_INSERT,  -32'sd1);
    add_req(OP_INSERT,  32'sd5);
    add_req(OP_INSERT,  32'sd5);
    add_cfg(7'd2);
    add_chk(OP_INSERT,  32'sd123,      32'sd0,        1'b0, 1'b1, 7'd6);
    add_chk(OP_EXTRACT, 32'shA5A5A5A5, 32'sh7FFFFFFF, 1'b1, 1'b0, 7'd5);
    add_req(OP_EXTRACT, 32'sh0F0F0F0F);
    add_req(OP_EXTRACT, 32'shF0F0F0F0);
    add_req(OP_EXTRACT, 32'sh7FFFFFFF);
    add_req(OP_EXTRACT, 32'sh80000000);
    add_req(OP_INSERT,  32'sh12345678);
    add_cfg(7'd0);
    add_chk(OP_INSERT,  32'sd42,       32'sd0,        1'b0, 1'b1, 7'd2);
    add_req(OP_EXTRACT, 32'shFFFFFFFF);
    add_chk(OP_EXTRACT, 32'sd0,        32'sh80000000, 1'b1, 1'b0, 7'd0);
    add_chk(OP_EXTRACT, 32'sh33333333, 32'sd0,        1'b0, 1'b0, 7'd0);
    add_cfg(7'd127);
    add_req(OP_INSERT,  -32'sd5);
    add_cfg(7'd1);
    add_chk(OP_INSERT,  32'sd9,        32'sd0,        1'b0, 1'b1, 7'd1);
    add_chk(OP_EXTRACT, 32'sh6B6B6B6B, -32'sd5,       1'b1, 1'b0, 7'd0);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      if (row.kind == ROW_CFG) begin
        write_limit(row.limit);
      end else begin
        send_request(row.op, row.key, row.typed, row.want);
      end
    end

    // Random part: each phase sets a limit, then runs a fill-heavy stretch
    // followed by a drain-heavy one, so the heap both fills toward its limit
    // and drains again. Keys mix full-range values, a narrow band that forces
    // ties, and the extremes.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      lim_code = phase_limit[ph];
      if (lim_code == LIM_RAND_LOW) lim_code = $urandom_range(HEAP_CAP, 1);
      else if (lim_code == LIM_RAND_HIGH) lim_code = $urandom_range(126, HEAP_CAP + 1);
      write_limit(lim_code[CFG_W-1:0]);
      no_idle = (ph == 9);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Long response stall while requests keep coming: the block must
        // back up and hold its request channel.
        if (ph == 5 && i == 10) rsp_hold_left = 400;
        // Sender goes quiet until the block has answered everything.
        if (ph == 7 && i == 50) drain_responses();
        fill_pct = (i < 70) ? 90 : 25;
        op = ($urandom_range(99) < fill_pct) ? OP_INSERT : OP_EXTRACT;
        case ($urandom_range(9))
          0: begin
            case ($urandom_range(3))
              0:       key = 32'sh7FFFFFFF;
              1:       key = 32'sh80000000;
              2:       key = '0;
              default: key = '1;
            endcase
          end
          1, 2, 3: begin
            key = $urandom_range(8);
            key = key - 32'sd4;
          end
          default: key = $urandom();
        endcase
        send_request(op, key, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_responses();
    repeat (20) @(posedge clk);

    $display("Run covered %0d inserts (%0d refused), %0d extracts (%0d on an empty heap).",
             n_inserts, n_refused, n_extracts, n_empty_pops);
    $display("%0d limit writes, deepest heap %0d keys, %0d responses checked.",
             n_limit_writes, deepest_fill, responses_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/bmhpq_pkg.sv
design/bmhpq_if.sv
design/bmhpq_mem.sv
design/bmhpq_ctrl.sv
design/binary_max_heap_priority_queue.sv
dv/testbench.sv
